>>> hw/rtl/pasg_pkg.sv
package pasg_pkg;

   localparam int unsigned ADDR_W_MAX = 13;
   localparam int unsigned ROM_W = 15;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   localparam logic [1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [1:0] CSR_VOLUME = 2'd1;
   localparam logic [1:0] CSR_BUFFER_LEN = 2'd2;

   localparam logic [31:0] PHASE_STEP_RESET = 32'd42852281;
   localparam logic [15:0] VOLUME_RESET = 16'd32768;
   localparam logic [15:0] BUFFER_LEN_RESET = 16'd1024;
   localparam logic [15:0] VOLUME_FULL = 16'h8000;

   typedef struct packed {
      logic [47:0] offset;
      logic last;
      logic neg;
      logic [ADDR_W_MAX-1:0] addr;
   } pasg_entry_type;

   // unsigned q2.62 product, top bits dropped
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // quarter-wave sine entry, evaluated at elaboration only
   function automatic logic [ROM_W-1:0] quarter_entry(input int unsigned q,
                                                      input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] sh;
      logic [63:0] sl;
      logic [63:0] t;
      logic [63:0] r;
      logic [63:0] lowmask;
      int k;
      lowmask = (64'd1 << tbits) - 64'd1;
      x = (HALF_PI_Q62 >> tbits) * 64'(q) + (((HALF_PI_Q62 & lowmask) * 64'(q)) >> tbits);
      x2 = mul_q62(x, x);
      term = x;
      s = x;
      for (k = 1; k <= 14; k++) begin
         term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
         if (k[0]) begin
            s = s - term;
         end else begin
            s = s + term;
         end
      end
      sh = s >> 32;
      sl = s & 64'hFFFF_FFFF;
      t = 64'd32767 * sh + ((64'd32767 * sl) >> 32);
      r = (t + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[ROM_W-1:0];
   endfunction

endpackage

>>> hw/rtl/pasg_front.sv
module pasg_front #(
   parameter int unsigned TABLE_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_restart,
   input  logic [31:0] phase_step,
   input  logic [15:0] buffer_len,
   input  logic q_ready,
   output logic q_push,
   output pasg_pkg::pasg_entry_type q_entry
);
   import pasg_pkg::*;

   localparam int unsigned ADDR_W = TABLE_BITS - 1;
   localparam int unsigned LOW_W = TABLE_BITS - 2;
   localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(1) << LOW_W;

   logic [31:0] phase_ff, phase_in;
   logic [47:0] count_ff, count_in;
   logic [15:0] pos_ff, pos_in;
   logic accept;
   logic [47:0] count_eff;
   logic [15:0] pos_eff;
   logic [15:0] size;
   logic [16:0] pos_next;
   logic last;
   logic [TABLE_BITS-1:0] idx;
   logic [LOW_W-1:0] low;
   logic [ADDR_W-1:0] addr;

   assign req_tready = q_ready;
   assign accept = req_tvalid && q_ready;

   always_comb begin
      count_eff = req_restart ? 48'd0 : count_ff;
      pos_eff = req_restart ? 16'd0 : pos_ff;
      size = (buffer_len == 16'd0) ? 16'd1 : buffer_len;
      pos_next = {1'b0, pos_eff} + 17'd1;
      last = pos_next >= {1'b0, size};
      phase_in = phase_ff + phase_step;
      idx = phase_in[31 -: TABLE_BITS];
      low = idx[LOW_W-1:0];
      addr = idx[LOW_W] ? (QUARTER - {1'b0, low}) : {1'b0, low};
      count_in = count_eff + 48'd1;
      pos_in = last ? 16'd0 : pos_next[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      q_push = accept;
      q_entry.offset = count_eff;
      q_entry.last = last;
      q_entry.neg = idx[TABLE_BITS-1];
      q_entry.addr = ADDR_W_MAX'(addr);
   end

endmodule

>>> hw/rtl/pasg_queue.sv
module pasg_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  pasg_pkg::pasg_entry_type push_entry,
   output logic ready,
   output logic head_valid,
   input  logic pop,
   output pasg_pkg::pasg_entry_type head_entry
);
   import pasg_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = 2;

   pasg_entry_type mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign ready = count_ff != (PTR_W + 1)'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push = push && ready;
      do_pop = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/pasg_back.sv
module pasg_back #(
   parameter int unsigned TABLE_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic [15:0] volume,
   input  logic q_valid,
   output logic q_pop,
   input  pasg_pkg::pasg_entry_type q_entry,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic signed [15:0] rsp_sample,
   output logic rsp_last,
   output logic [47:0] rsp_offset
);
   import pasg_pkg::*;

   localparam int unsigned ADDR_W = TABLE_BITS - 1;
   localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);

   logic [ROM_W-1:0] rom_table [0:QUARTER];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [ROM_W-1:0] ENTRY = quarter_entry(4 * g, TABLE_BITS);
      assign rom_table[g] = ENTRY;
   end

   logic advance;
   logic [15:0] vol_sat;

   logic s1_valid_ff, s1_valid_in;
   logic [ROM_W-1:0] s1_mag_ff;
   logic s1_neg_ff, s1_last_ff;
   logic [47:0] s1_offset_ff;

   logic s2_valid_ff;
   logic [29:0] s2_prod_ff, s2_prod_in;
   logic s2_neg_ff, s2_last_ff;
   logic [47:0] s2_offset_ff;

   logic out_valid_ff;
   logic [15:0] out_sample_ff, out_sample_in;
   logic out_last_ff;
   logic [47:0] out_offset_ff;

   always_comb begin
      advance = !out_valid_ff || rsp_tready;
      q_pop = advance && q_valid;
      s1_valid_in = q_valid;
      vol_sat = (volume > VOLUME_FULL) ? VOLUME_FULL : volume;
      s2_prod_in = 30'({15'd0, s1_mag_ff} * {14'd0, vol_sat});
      out_sample_in = s2_neg_ff ? (16'd0 - {1'b0, s2_prod_ff[29:15]})
                                : {1'b0, s2_prod_ff[29:15]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // rom read, multiply, sign stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff <= rom_table[q_entry.addr[ADDR_W-1:0]];
         s1_neg_ff <= q_entry.neg;
         s1_last_ff <= q_entry.last;
         s1_offset_ff <= q_entry.offset;
         s2_prod_ff <= s2_prod_in;
         s2_neg_ff <= s1_neg_ff;
         s2_last_ff <= s1_last_ff;
         s2_offset_ff <= s1_offset_ff;
         out_sample_ff <= out_sample_in;
         out_last_ff <= s2_last_ff;
         out_offset_ff <= s2_offset_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last = out_last_ff;
   assign rsp_offset = out_offset_ff;

endmodule

>>> hw/rtl/phase_accumulator_sine_generator_unit.sv
// path: an accepted word is written into a four-entry queue, then registered
// in the rom, multiply and sign stages; throughput: one word per cycle while
// rsp_tready holds, set by the single-add phase accumulator and three stages
// reset: synchronous; phase, sample offset and buffer position clear, the
// registers return to their power-on values and all pipeline words are dropped
module phase_accumulator_sine_generator_unit #(
   parameter int unsigned TABLE_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [0] restart, [7:1] zero
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [63:0] rsp_tdata,  // [15:0] sample, [63:16] sample_offset
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import pasg_pkg::*;

   logic [31:0] phase_step_ff;
   logic [15:0] volume_ff;
   logic [15:0] buffer_len_ff;

   logic q_ready, q_push, q_valid, q_pop;
   pasg_entry_type push_entry, head_entry;
   logic signed [15:0] sample;
   logic [47:0] offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         volume_ff <= VOLUME_RESET;
         buffer_len_ff <= BUFFER_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_VOLUME: volume_ff <= csr_wdata[15:0];
            CSR_BUFFER_LEN: buffer_len_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   pasg_front #(
      .TABLE_BITS(TABLE_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_restart(req_tdata[0]),
      .phase_step(phase_step_ff),
      .buffer_len(buffer_len_ff),
      .q_ready(q_ready),
      .q_push(q_push),
      .q_entry(push_entry)
   );

   pasg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_entry(push_entry),
      .ready(q_ready),
      .head_valid(q_valid),
      .pop(q_pop),
      .head_entry(head_entry)
   );

   pasg_back #(
      .TABLE_BITS(TABLE_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .volume(volume_ff),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_entry(head_entry),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_sample(sample),
      .rsp_last(rsp_tlast),
      .rsp_offset(offset)
   );

   assign rsp_tdata = {offset, sample};

endmodule
